/* hw/rtl/ps2_keyboard_controller_macros.svh */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller assertion macros
// Shared concurrent assertion wrappers, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_CONTROLLER_MACROS_SVH
`define PS2_KEYBOARD_CONTROLLER_MACROS_SVH

// Implication check sampled on the rising clock edge, off while in reset.
`define PS2KC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain invariant that must hold at every clock edge out of reset.
`define PS2KC_ALWAYS(lbl, expr, msg) \
	`PS2KC_ASSERT(lbl, (1'b1 |-> (expr)), msg)

`endif

/* hw/rtl/ps2kc_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller package
// Payload types, state types, command codes and decode helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2kc_pkg;

	localparam int RAM_BYTES  = 32;
	localparam int PULSE_BITS = 14;

	localparam logic [15:0] DAT_PORT_RESET  = 16'h0060;
	localparam logic [15:0] CMD_PORT_RESET  = 16'h0064;
	localparam logic [7:0]  STATUS_RESET    = 8'h1C;
	localparam logic [7:0]  CONTROL_RESET   = 8'h45;

	// Status byte bits.
	localparam int ST_OUT_FULL  = 0;
	localparam int ST_SELFTEST  = 2;
	localparam int ST_CMD_LAST  = 3;
	localparam int ST_MOUSE_OUT = 5;

	// Control byte bits.
	localparam int CB_KBD_INT   = 0;
	localparam int CB_MOUSE_INT = 1;
	localparam int CB_KBD_OFF   = 4;
	localparam int CB_MOUSE_OFF = 5;

	typedef enum logic [1:0] {
		ACT_HOST_READ  = 2'd0,
		ACT_HOST_WRITE = 2'd1,
		ACT_KBD_REPLY  = 2'd2,
		ACT_MOUSE_REPLY = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_BAD_ADDR = 3'd1,
		ERR_UNIMPL   = 3'd2,
		ERR_RESET_BIT = 3'd3,
		ERR_UNKNOWN  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		PC_NONE     = 3'd0,
		PC_CTRL     = 3'd1,
		PC_OUTPORT  = 3'd2,
		PC_KBDBUF   = 3'd3,
		PC_MOUSEBUF = 3'd4,
		PC_TOMOUSE  = 3'd5
	} pend_t;

	typedef enum logic [0:0] {
		CFG_DAT_PORT = 1'b0,
		CFG_CMD_PORT = 1'b1
	} cfg_idx_t;

	// Controller commands that are carried out.
	localparam logic [7:0] CMD_READ_CTRL   = 8'h20;
	localparam logic [7:0] CMD_WRITE_CTRL  = 8'h60;
	localparam logic [7:0] CMD_MOUSE_OFF   = 8'hA7;
	localparam logic [7:0] CMD_MOUSE_ON    = 8'hA8;
	localparam logic [7:0] CMD_KBD_OFF     = 8'hAD;
	localparam logic [7:0] CMD_KBD_ON      = 8'hAE;
	localparam logic [7:0] CMD_WRITE_OUTP  = 8'hD1;
	localparam logic [7:0] CMD_WRITE_KBUF  = 8'hD2;
	localparam logic [7:0] CMD_WRITE_MBUF  = 8'hD3;
	localparam logic [7:0] CMD_TO_MOUSE    = 8'hD4;

	// Range bases of the RAM access and output pulse command groups.
	localparam logic [8:0] RAM_RD_BASE = 9'h020;
	localparam logic [8:0] RAM_WR_BASE = 9'h060;
	localparam logic [8:0] PULSE_BASE  = 9'h0F0;
	localparam logic [8:0] RAM_RD_END  = 9'(32'h20 + RAM_BYTES);
	localparam logic [8:0] RAM_WR_END  = 9'(32'h60 + RAM_BYTES);
	localparam logic [8:0] PULSE_END   = 9'(32'hF0 + PULSE_BITS);

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] io_address;
		logic [7:0]  write_byte;
		logic        kbd_pending;
		logic [7:0]  kbd_byte;
		logic        mouse_pending;
		logic [7:0]  mouse_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       kbd_pop;
		logic       mouse_pop;
		logic       kbd_send_valid;
		logic       mouse_send_valid;
		logic [7:0] send_byte;
		logic       kbd_irq_pulse;
		logic       mouse_irq_pulse;
		logic [2:0] error_code;
	} rsp_t;

	typedef struct packed {
		logic [7:0] status;
		logic [7:0] control;
		logic [7:0] out_data;
		logic [2:0] pending;
	} ctl_state_t;

	typedef struct packed {
		logic [15:0] dat_port;
		logic [15:0] cmd_port;
	} port_cfg_t;

	// Commands that the controller recognizes but does not implement.
	function automatic logic is_unimplemented(input logic [7:0] c);
		logic [8:0] cw;
		logic       hit;
		cw  = {1'b0, c};
		hit = ((cw > RAM_RD_BASE) && (cw < RAM_RD_END)) ||
		      ((cw > RAM_WR_BASE) && (cw < RAM_WR_END)) ||
		      ((cw >= PULSE_BASE) && (cw < PULSE_END));
		unique case (c)
			8'hA4, 8'hA5, 8'hA6, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hC0, 8'hC1,
			8'hC2, 8'hD0, 8'hDD, 8'hDF, 8'hE0, 8'hFE: hit = 1'b1;
			default: ;
		endcase
		return hit;
	endfunction

endpackage

/* hw/rtl/ps2kc_req_if.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller request channel
// Valid/ready channel carrying one bus access or device event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ps2kc_req_if;
	logic            valid;
	logic            ready;
	ps2kc_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ps2kc_rsp_if.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller response channel
// Valid/ready channel carrying one result per accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ps2kc_rsp_if;
	logic            valid;
	logic            ready;
	ps2kc_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ps2kc_exec.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller execute logic
// Decodes one request against the controller state and forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2kc_exec (
	input  ps2kc_pkg::req_t       req,
	input  ps2kc_pkg::ctl_state_t cur,
	input  ps2kc_pkg::port_cfg_t  cfg,
	output ps2kc_pkg::ctl_state_t nxt,
	output ps2kc_pkg::rsp_t       rsp
);

	logic       is_data;
	logic       is_cmd;
	logic       ld;
	logic [7:0] ld_val;
	logic       ld_mouse;

	assign is_data = (req.io_address == cfg.dat_port);
	assign is_cmd  = (req.io_address == cfg.cmd_port);

	always_comb begin
		nxt      = cur;
		rsp      = '0;
		ld       = 1'b0;
		ld_val   = '0;
		ld_mouse = 1'b0;

		unique case (req.action)
			ps2kc_pkg::ACT_HOST_READ: begin
				if (is_data) begin
					rsp.read_byte = cur.out_data;
					nxt.status[ps2kc_pkg::ST_OUT_FULL]  = 1'b0;
					nxt.status[ps2kc_pkg::ST_MOUSE_OUT] = 1'b0;
					if (req.kbd_pending) begin
						ld = 1'b1;
						ld_val = req.kbd_byte;
						rsp.kbd_pop = 1'b1;
					end else if (req.mouse_pending) begin
						ld = 1'b1;
						ld_val = req.mouse_byte;
						ld_mouse = 1'b1;
						rsp.mouse_pop = 1'b1;
					end
				end else if (is_cmd) begin
					rsp.read_byte = cur.status;
				end else begin
					rsp.error_code = ps2kc_pkg::ERR_BAD_ADDR;
				end
			end
			ps2kc_pkg::ACT_HOST_WRITE: begin
				if (is_data) begin
					nxt.status[ps2kc_pkg::ST_CMD_LAST] = 1'b0;
					nxt.pending = ps2kc_pkg::PC_NONE;
					unique case (cur.pending)
						ps2kc_pkg::PC_NONE: begin
							rsp.kbd_send_valid = 1'b1;
							rsp.send_byte = req.write_byte;
							if (req.kbd_pending) begin
								ld = 1'b1;
								ld_val = req.kbd_byte;
								rsp.kbd_pop = 1'b1;
							end
						end
						ps2kc_pkg::PC_TOMOUSE: begin
							rsp.mouse_send_valid = 1'b1;
							rsp.send_byte = req.write_byte;
							if (req.mouse_pending) begin
								ld = 1'b1;
								ld_val = req.mouse_byte;
								ld_mouse = 1'b1;
								rsp.mouse_pop = 1'b1;
							end
						end
						ps2kc_pkg::PC_CTRL: begin
							nxt.control = req.write_byte;
							nxt.status[ps2kc_pkg::ST_SELFTEST] =
								req.write_byte[ps2kc_pkg::ST_SELFTEST];
						end
						ps2kc_pkg::PC_MOUSEBUF: begin
							ld = 1'b1;
							ld_val = req.write_byte;
							ld_mouse = 1'b1;
						end
						ps2kc_pkg::PC_KBDBUF: begin
							ld = 1'b1;
							ld_val = req.write_byte;
						end
						ps2kc_pkg::PC_OUTPORT: begin
							if (!req.write_byte[0]) begin
								rsp.error_code = ps2kc_pkg::ERR_RESET_BIT;
							end
						end
						default: rsp.error_code = ps2kc_pkg::ERR_UNIMPL;
					endcase
				end else if (is_cmd) begin
					nxt.status[ps2kc_pkg::ST_CMD_LAST] = 1'b1;
					if (ps2kc_pkg::is_unimplemented(req.write_byte)) begin
						rsp.error_code = ps2kc_pkg::ERR_UNIMPL;
					end else begin
						unique case (req.write_byte)
							ps2kc_pkg::CMD_READ_CTRL: begin
								ld = 1'b1;
								ld_val = cur.control;
							end
							ps2kc_pkg::CMD_WRITE_CTRL: nxt.pending = ps2kc_pkg::PC_CTRL;
							ps2kc_pkg::CMD_MOUSE_OFF:
								nxt.control[ps2kc_pkg::CB_MOUSE_OFF] = 1'b1;
							ps2kc_pkg::CMD_MOUSE_ON:
								nxt.control[ps2kc_pkg::CB_MOUSE_OFF] = 1'b0;
							ps2kc_pkg::CMD_KBD_OFF:
								nxt.control[ps2kc_pkg::CB_KBD_OFF] = 1'b1;
							ps2kc_pkg::CMD_KBD_ON:
								nxt.control[ps2kc_pkg::CB_KBD_OFF] = 1'b0;
							ps2kc_pkg::CMD_WRITE_OUTP: nxt.pending = ps2kc_pkg::PC_OUTPORT;
							ps2kc_pkg::CMD_WRITE_KBUF: nxt.pending = ps2kc_pkg::PC_KBDBUF;
							ps2kc_pkg::CMD_WRITE_MBUF: nxt.pending = ps2kc_pkg::PC_MOUSEBUF;
							ps2kc_pkg::CMD_TO_MOUSE:   nxt.pending = ps2kc_pkg::PC_TOMOUSE;
							default: rsp.error_code = ps2kc_pkg::ERR_UNKNOWN;
						endcase
					end
				end else begin
					rsp.error_code = ps2kc_pkg::ERR_BAD_ADDR;
				end
			end
			ps2kc_pkg::ACT_KBD_REPLY: begin
				if (req.kbd_pending && !cur.status[ps2kc_pkg::ST_OUT_FULL]) begin
					ld = 1'b1;
					ld_val = req.kbd_byte;
					rsp.kbd_pop = 1'b1;
				end
			end
			default: begin
				if (req.mouse_pending && !cur.status[ps2kc_pkg::ST_OUT_FULL]) begin
					ld = 1'b1;
					ld_val = req.mouse_byte;
					ld_mouse = 1'b1;
					rsp.mouse_pop = 1'b1;
				end
			end
		endcase

		// Loading the output buffer marks it full, tags its source and may
		// raise the matching interrupt.
		if (ld) begin
			nxt.out_data = ld_val;
			nxt.status[ps2kc_pkg::ST_OUT_FULL]  = 1'b1;
			nxt.status[ps2kc_pkg::ST_MOUSE_OUT] = ld_mouse;
			rsp.kbd_irq_pulse   = !ld_mouse && cur.control[ps2kc_pkg::CB_KBD_INT];
			rsp.mouse_irq_pulse = ld_mouse && cur.control[ps2kc_pkg::CB_MOUSE_INT];
		end
	end

endmodule

/* hw/rtl/ps2_keyboard_controller.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller
// 8042-style register model: host port accesses and device replies.
// ----------------------------------------------------------------------------
// Each request transaction on "req" is one host read or write at an I/O
// address, or a keyboard or mouse reply event with the device head bytes.
// Every request produces exactly one response transaction on "rsp", in order.
// The request is first captured in an input register; the execute logic then
// updates the controller state (status, control byte, output buffer, pending
// two-byte command) and fills the response register once that register is
// free or drains, so a request is held in the input register while the
// response register is stalled. One request is accepted every cycle while
// the response side keeps up.
// When the response receiver stalls, the finished response is held, one more
// request waits in the input register, and only then does req.ready drop.
// The port addresses are set through the cfg write port and must only be
// changed while no transaction is in flight.
// Reset clears both pipeline valid bits and returns the state to the
// power-on values: status 0x1C, control byte 0x45, empty output buffer,
// no pending command, ports 0x60 and 0x64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_keyboard_controller_macros.svh"

module ps2_keyboard_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	ps2kc_req_if.sink            req,
	ps2kc_rsp_if.source          rsp,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_wdata
);

	ps2kc_pkg::port_cfg_t  cfg_q;
	ps2kc_pkg::ctl_state_t state_q;
	ps2kc_pkg::ctl_state_t state_nxt;
	ps2kc_pkg::req_t       req_s1;
	logic                  valid_s1;
	ps2kc_pkg::rsp_t       rsp_q;
	ps2kc_pkg::rsp_t       rsp_nxt;
	logic                  rsp_valid_q;
	logic                  exec_fire;

	// The execute stage fires when the response register is free or drains.
	assign exec_fire = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || exec_fire;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Port address registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dat_port <= ps2kc_pkg::DAT_PORT_RESET;
			cfg_q.cmd_port <= ps2kc_pkg::CMD_PORT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ps2kc_pkg::CFG_DAT_PORT: cfg_q.dat_port <= cfg_wdata;
				default:                 cfg_q.cmd_port <= cfg_wdata;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	ps2kc_exec u_exec (
		.req (req_s1),
		.cur (state_q),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// Controller state is committed together with the response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.status   <= ps2kc_pkg::STATUS_RESET;
			state_q.control  <= ps2kc_pkg::CONTROL_RESET;
			state_q.out_data <= '0;
			state_q.pending  <= ps2kc_pkg::PC_NONE;
		end else if (exec_fire) begin
			state_q <= state_nxt;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	// An interrupt pulse always comes with a full output buffer.
	`PS2KC_ASSERT(a_irq_full, exec_fire |=> (!(rsp_q.kbd_irq_pulse || rsp_q.mouse_irq_pulse) || state_q.status[ps2kc_pkg::ST_OUT_FULL]), "interrupt without full output buffer")
	// At most one device is popped or sent to per transaction.
	`PS2KC_ASSERT(a_one_device, exec_fire |=> ($onehot0({rsp_q.kbd_pop, rsp_q.mouse_pop}) && $onehot0({rsp_q.kbd_send_valid, rsp_q.mouse_send_valid})), "two devices served at once")
	// The pending command register never holds an undefined code.
	`PS2KC_ALWAYS(a_pending_code, (state_q.pending <= ps2kc_pkg::PC_TOMOUSE), "bad pending command code")

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// PS/2 keyboard controller testbench
// Drives host accesses and device reply events into the controller, predicts
// every response with an in-bench copy of the 8042 register behavior, and
// checks each response field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	// Commands that the controller recognizes but refuses. The RAM access and
	// output pulse groups are ranges and are decoded arithmetically below.
	localparam logic [7:0] CMD_PW_TEST     = 8'hA4;
	localparam logic [7:0] CMD_PW_LOAD     = 8'hA5;
	localparam logic [7:0] CMD_PW_CHECK    = 8'hA6;
	localparam logic [7:0] CMD_MOUSE_TEST  = 8'hA9;
	localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
	localparam logic [7:0] CMD_KBD_TEST    = 8'hAB;
	localparam logic [7:0] CMD_DUMP        = 8'hAC;
	localparam logic [7:0] CMD_RD_INPORT   = 8'hC0;
	localparam logic [7:0] CMD_POLL_LO     = 8'hC1;
	localparam logic [7:0] CMD_POLL_HI     = 8'hC2;
	localparam logic [7:0] CMD_RD_OUTPORT  = 8'hD0;
	localparam logic [7:0] CMD_A20_OFF     = 8'hDD;
	localparam logic [7:0] CMD_A20_ON      = 8'hDF;
	localparam logic [7:0] CMD_RD_TESTIN   = 8'hE0;
	localparam logic [7:0] CMD_SYS_RESET   = 8'hFE;
	// A few edge codes used by the directed part.
	localparam logic [7:0] CMD_RAM_RD_LOW  = 8'h21;
	localparam logic [7:0] CMD_PULSE_LAST  = 8'hFD;
	localparam logic [7:0] CMD_NOT_DEFINED = 8'hFF;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	ps2kc_req_if req ();
	ps2kc_rsp_if rsp ();

	ps2_keyboard_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Controller state as the bench believes it to be. It is advanced once per
	// accepted request transaction, in acceptance order, so it always matches
	// the state the block will have when that request executes.
	// ------------------------------------------------------------------------
	logic [7:0]        kc_status;
	logic [7:0]        kc_control;
	logic [7:0]        kc_out;
	ps2kc_pkg::pend_t  kc_pending;
	logic [15:0]       port_data;
	logic [15:0]       port_cmd;
	logic              irq_kbd;
	logic              irq_mouse;

	ps2kc_pkg::req_t bus_events_q[$];   // requests waiting for the driver
	ps2kc_pkg::rsp_t replies_due[$];    // predicted responses, oldest first

	int  n_issued = 0;       // requests handed to the driver so far
	int  n_replied = 0;      // response transactions seen
	int  n_mismatch = 0;
	int  n_settings = 0;
	int  n_kirq = 0;
	int  n_mirq = 0;
	int  err_hist[8];
	int  send_gap = 0;
	int  hold_cnt = 0;
	logic req_fire = 1'b0;
	bit  steady_run = 1'b0;  // while set, neither side inserts idle cycles

	function automatic void controller_reset();
		kc_status  = ps2kc_pkg::STATUS_RESET;
		kc_control = ps2kc_pkg::CONTROL_RESET;
		kc_out     = 8'h00;
		kc_pending = ps2kc_pkg::PC_NONE;
		port_data  = ps2kc_pkg::DAT_PORT_RESET;
		port_cmd   = ps2kc_pkg::CMD_PORT_RESET;
	endfunction

	// Every load of the output buffer marks it full, records which device it
	// came from and fires that device's interrupt if the control byte allows.
	function automatic void fill_output(input logic [7:0] v, input logic from_mouse);
		kc_out = v;
		kc_status[ps2kc_pkg::ST_OUT_FULL] = 1'b1;
		kc_status[ps2kc_pkg::ST_MOUSE_OUT] = from_mouse;
		if (!from_mouse && kc_control[ps2kc_pkg::CB_KBD_INT])
			irq_kbd = 1'b1;
		else if (from_mouse && kc_control[ps2kc_pkg::CB_MOUSE_INT])
			irq_mouse = 1'b1;
	endfunction

	function automatic bit cmd_is_reserved(input logic [7:0] c);
		int v;
		v = c;
		if (v > int'(ps2kc_pkg::RAM_RD_BASE) &&
		    v < int'(ps2kc_pkg::RAM_RD_BASE) + ps2kc_pkg::RAM_BYTES)
			return 1'b1;
		if (v > int'(ps2kc_pkg::RAM_WR_BASE) &&
		    v < int'(ps2kc_pkg::RAM_WR_BASE) + ps2kc_pkg::RAM_BYTES)
			return 1'b1;
		if (v >= int'(ps2kc_pkg::PULSE_BASE) &&
		    v < int'(ps2kc_pkg::PULSE_BASE) + ps2kc_pkg::PULSE_BITS)
			return 1'b1;
		case (c)
			CMD_PW_TEST, CMD_PW_LOAD, CMD_PW_CHECK, CMD_MOUSE_TEST, CMD_SELF_TEST,
			CMD_KBD_TEST, CMD_DUMP, CMD_RD_INPORT, CMD_POLL_LO, CMD_POLL_HI,
			CMD_RD_OUTPORT, CMD_A20_OFF, CMD_A20_ON, CMD_RD_TESTIN,
			CMD_SYS_RESET: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit takes_operand(input logic [7:0] c);
		return c == ps2kc_pkg::CMD_WRITE_CTRL || c == ps2kc_pkg::CMD_WRITE_OUTP ||
		       c == ps2kc_pkg::CMD_WRITE_KBUF || c == ps2kc_pkg::CMD_WRITE_MBUF ||
		       c == ps2kc_pkg::CMD_TO_MOUSE;
	endfunction

	// Works out the response to one request and moves the state on.
	function automatic ps2kc_pkg::rsp_t controller_step(input ps2kc_pkg::req_t r);
		ps2kc_pkg::rsp_t o;
		o = '0;
		o.error_code = ps2kc_pkg::ERR_OK;
		irq_kbd = 1'b0;
		irq_mouse = 1'b0;
		case (ps2kc_pkg::action_t'(r.action))
			ps2kc_pkg::ACT_HOST_READ: begin
				if (r.io_address == port_data) begin
					// The read drains the buffer, then the keyboard refills it
					// first and the mouse only when the keyboard has nothing.
					o.read_byte = kc_out;
					kc_status[ps2kc_pkg::ST_OUT_FULL] = 1'b0;
					kc_status[ps2kc_pkg::ST_MOUSE_OUT] = 1'b0;
					if (r.kbd_pending) begin
						fill_output(r.kbd_byte, 1'b0);
						o.kbd_pop = 1'b1;
					end else if (r.mouse_pending) begin
						fill_output(r.mouse_byte, 1'b1);
						o.mouse_pop = 1'b1;
					end
				end else if (r.io_address == port_cmd) begin
					o.read_byte = kc_status;
				end else begin
					o.error_code = ps2kc_pkg::ERR_BAD_ADDR;
				end
			end
			ps2kc_pkg::ACT_HOST_WRITE: begin
				if (r.io_address == port_data) begin
					kc_status[ps2kc_pkg::ST_CMD_LAST] = 1'b0;
					case (kc_pending)
						ps2kc_pkg::PC_NONE: begin
							o.kbd_send_valid = 1'b1;
							o.send_byte = r.write_byte;
							if (r.kbd_pending) begin
								fill_output(r.kbd_byte, 1'b0);
								o.kbd_pop = 1'b1;
							end
						end
						ps2kc_pkg::PC_TOMOUSE: begin
							o.mouse_send_valid = 1'b1;
							o.send_byte = r.write_byte;
							if (r.mouse_pending) begin
								fill_output(r.mouse_byte, 1'b1);
								o.mouse_pop = 1'b1;
							end
						end
						ps2kc_pkg::PC_CTRL: begin
							kc_control = r.write_byte;
							kc_status[ps2kc_pkg::ST_SELFTEST] =
								r.write_byte[ps2kc_pkg::ST_SELFTEST];
						end
						ps2kc_pkg::PC_MOUSEBUF: fill_output(r.write_byte, 1'b1);
						ps2kc_pkg::PC_KBDBUF: fill_output(r.write_byte, 1'b0);
						ps2kc_pkg::PC_OUTPORT: begin
							if (!r.write_byte[0])
								o.error_code = ps2kc_pkg::ERR_RESET_BIT;
						end
						default: o.error_code = ps2kc_pkg::ERR_UNIMPL;
					endcase
					kc_pending = ps2kc_pkg::PC_NONE;
				end else if (r.io_address == port_cmd) begin
					// One-byte commands leave an earlier two-byte command armed.
					kc_status[ps2kc_pkg::ST_CMD_LAST] = 1'b1;
					if (cmd_is_reserved(r.write_byte)) begin
						o.error_code = ps2kc_pkg::ERR_UNIMPL;
					end else begin
						case (r.write_byte)
							ps2kc_pkg::CMD_READ_CTRL: fill_output(kc_control, 1'b0);
							ps2kc_pkg::CMD_WRITE_CTRL: kc_pending = ps2kc_pkg::PC_CTRL;
							ps2kc_pkg::CMD_MOUSE_OFF:
								kc_control[ps2kc_pkg::CB_MOUSE_OFF] = 1'b1;
							ps2kc_pkg::CMD_MOUSE_ON:
								kc_control[ps2kc_pkg::CB_MOUSE_OFF] = 1'b0;
							ps2kc_pkg::CMD_KBD_OFF:
								kc_control[ps2kc_pkg::CB_KBD_OFF] = 1'b1;
							ps2kc_pkg::CMD_KBD_ON:
								kc_control[ps2kc_pkg::CB_KBD_OFF] = 1'b0;
							ps2kc_pkg::CMD_WRITE_OUTP: kc_pending = ps2kc_pkg::PC_OUTPORT;
							ps2kc_pkg::CMD_WRITE_KBUF: kc_pending = ps2kc_pkg::PC_KBDBUF;
							ps2kc_pkg::CMD_WRITE_MBUF: kc_pending = ps2kc_pkg::PC_MOUSEBUF;
							ps2kc_pkg::CMD_TO_MOUSE: kc_pending = ps2kc_pkg::PC_TOMOUSE;
							default: o.error_code = ps2kc_pkg::ERR_UNKNOWN;
						endcase
					end
				end else begin
					o.error_code = ps2kc_pkg::ERR_BAD_ADDR;
				end
			end
			ps2kc_pkg::ACT_KBD_REPLY: begin
				// A device reply only lands in an empty output buffer.
				if (r.kbd_pending && !kc_status[ps2kc_pkg::ST_OUT_FULL]) begin
					fill_output(r.kbd_byte, 1'b0);
					o.kbd_pop = 1'b1;
				end
			end
			default: begin
				if (r.mouse_pending && !kc_status[ps2kc_pkg::ST_OUT_FULL]) begin
					fill_output(r.mouse_byte, 1'b1);
					o.mouse_pop = 1'b1;
				end
			end
		endcase
		o.kbd_irq_pulse = irq_kbd;
		o.mouse_irq_pulse = irq_mouse;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Mismatch reporting. Every failure goes through report_mismatch, which
	// keeps counting after the first hundred lines but stops printing.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		if (n_mismatch < 100)
			$display("[%0t] MISMATCH %s", $time, what);
		n_mismatch++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%02h want 0x%02h", name, got, want));
	endtask

	// Idle lengths: mostly none, often short, now and then a long one.
	function automatic int draw_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady_run || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. Inputs change on the falling edge only. A new request
	// is presented when the channel is empty or the previous transaction was
	// taken at the last rising edge, after the random gap has run out.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req_fire) begin
			if (send_gap > 0) begin
				req.valid <= 1'b0;
				send_gap = send_gap - 1;
			end else if (bus_events_q.size() > 0) begin
				req.valid <= 1'b1;
				req.data <= bus_events_q.pop_front();
				send_gap = draw_idle();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Response receiver: ready drops for random stretches, so stalls land on
	// every stage of the pipeline, including a full input register.
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			rsp.ready <= 1'b0;
			hold_cnt = hold_cnt - 1;
		end else begin
			rsp.ready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				hold_cnt = draw_idle();
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Both channels are sampled on the rising edge, where every
	// input is stable and the block's outputs still hold their old values.
	// An accepted request is predicted at once; a response transaction is
	// checked against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		ps2kc_pkg::rsp_t got;
		ps2kc_pkg::rsp_t want;
		req_fire <= req.valid && req.ready;
		if (arst_n && req.valid && req.ready)
			replies_due.insert(replies_due.size(), controller_step(req.data));
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			n_replied++;
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("response with nothing outstanding: %h", got));
			end else begin
				want = replies_due.pop_front();
				check_field("read_byte", got.read_byte, want.read_byte);
				check_field("kbd_pop", 8'(got.kbd_pop), 8'(want.kbd_pop));
				check_field("mouse_pop", 8'(got.mouse_pop), 8'(want.mouse_pop));
				check_field("kbd_send_valid", 8'(got.kbd_send_valid),
					8'(want.kbd_send_valid));
				check_field("mouse_send_valid", 8'(got.mouse_send_valid),
					8'(want.mouse_send_valid));
				check_field("send_byte", got.send_byte, want.send_byte);
				check_field("kbd_irq_pulse", 8'(got.kbd_irq_pulse),
					8'(want.kbd_irq_pulse));
				check_field("mouse_irq_pulse", 8'(got.mouse_irq_pulse),
					8'(want.mouse_irq_pulse));
				check_field("error_code", 8'(got.error_code), 8'(want.error_code));
				err_hist[want.error_code]++;
				n_kirq += int'(want.kbd_irq_pulse);
				n_mirq += int'(want.mouse_irq_pulse);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic void queue_access(input ps2kc_pkg::action_t act,
			input logic [15:0] addr,
			input logic [7:0] wb, input logic kp, input logic [7:0] kb,
			input logic mp, input logic [7:0] mb);
		ps2kc_pkg::req_t r;
		r.action        = act;
		r.io_address    = addr;
		r.write_byte    = wb;
		r.kbd_pending   = kp;
		r.kbd_byte      = kb;
		r.mouse_pending = mp;
		r.mouse_byte    = mb;
		bus_events_q.insert(bus_events_q.size(), r);
		n_issued++;
	endfunction

	// Same request with the device queue heads drawn at random.
	function automatic void queue_random_fields(input ps2kc_pkg::action_t act,
			input logic [15:0] addr, input logic [7:0] wb);
		queue_access(act, addr, wb, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
	endfunction

	function automatic logic [7:0] pick_command();
		logic [7:0] c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case ($urandom_range(0, 9))
				0: c = ps2kc_pkg::CMD_READ_CTRL;
				1: c = ps2kc_pkg::CMD_WRITE_CTRL;
				2: c = ps2kc_pkg::CMD_MOUSE_OFF;
				3: c = ps2kc_pkg::CMD_MOUSE_ON;
				4: c = ps2kc_pkg::CMD_KBD_OFF;
				5: c = ps2kc_pkg::CMD_KBD_ON;
				6: c = ps2kc_pkg::CMD_WRITE_OUTP;
				7: c = ps2kc_pkg::CMD_WRITE_KBUF;
				8: c = ps2kc_pkg::CMD_WRITE_MBUF;
				default: c = ps2kc_pkg::CMD_TO_MOUSE;
			endcase
		end else if (r < 80) begin
			do
				c = 8'($urandom);
			while (!cmd_is_reserved(c));
		end else begin
			c = 8'($urandom);
		end
		return c;
	endfunction

	// Most random traffic is well formed: a command is usually followed by
	// its operand, and reads keep pulling device bytes through the buffer.
	// The last slice is noise with any action at any address.
	function automatic void queue_random_sequence();
		int unsigned pick;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			c = pick_command();
			queue_random_fields(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, c);
			if (takes_operand(c) && $urandom_range(0, 9) < 8)
				queue_random_fields(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'($urandom));
		end else if (pick < 38) begin
			queue_random_fields(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'($urandom));
		end else if (pick < 60) begin
			queue_random_fields(ps2kc_pkg::ACT_HOST_READ, port_data, 8'($urandom));
		end else if (pick < 68) begin
			queue_random_fields(ps2kc_pkg::ACT_HOST_READ, port_cmd, 8'($urandom));
		end else if (pick < 78) begin
			queue_random_fields(ps2kc_pkg::ACT_KBD_REPLY, 16'($urandom), 8'($urandom));
		end else if (pick < 88) begin
			queue_random_fields(ps2kc_pkg::ACT_MOUSE_REPLY, 16'($urandom), 8'($urandom));
		end else begin
			queue_random_fields(ps2kc_pkg::action_t'($urandom_range(0, 3)),
				16'($urandom), 8'($urandom));
		end
	endfunction

	// Holds the stimulus until every issued request has been answered, then
	// lets the pipeline settle.
	task automatic wait_until_drained();
		while (n_replied < n_issued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Port registers change only while nothing is in flight.
	task automatic write_port_cfg(input ps2kc_pkg::cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == ps2kc_pkg::CFG_DAT_PORT)
			port_data = value;
		else
			port_cmd = value;
	endtask

	// One random phase under one port setting. Halfway through, the sender
	// waits for every outstanding response before it carries on.
	task automatic run_random_phase(input logic [15:0] dp, input logic [15:0] cp,
			input int count);
		int first;
		wait_until_drained();
		write_port_cfg(ps2kc_pkg::CFG_DAT_PORT, dp);
		write_port_cfg(ps2kc_pkg::CFG_CMD_PORT, cp);
		n_settings++;
		first = n_issued;
		while (n_issued - first < count) begin
			if (n_issued - first >= count / 2 && n_issued - first < count / 2 + 2)
				wait_until_drained();
			// Keep the driver queue short so idle modes change in real time.
			while (bus_events_q.size() > 4)
				@(negedge clk);
			if (steady_run ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 63) == 0))
				steady_run = !steady_run;
			queue_random_sequence();
		end
		steady_run = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset, a directed walk through every carried-out command and
	// corner under the power-on ports, then random phases under several port
	// settings including both extremes and the case where both are equal.
	// ------------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = ps2kc_pkg::CFG_DAT_PORT;
		cfg_wdata = 16'h0000;
		controller_reset();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		write_port_cfg(ps2kc_pkg::CFG_DAT_PORT, ps2kc_pkg::DAT_PORT_RESET);
		write_port_cfg(ps2kc_pkg::CFG_CMD_PORT, ps2kc_pkg::CMD_PORT_RESET);
		n_settings++;

		// Status straight out of reset, then a data read that pulls a waiting
		// keyboard byte into the buffer and raises the keyboard interrupt.
		queue_access(ps2kc_pkg::ACT_HOST_READ, port_cmd, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_READ, port_data, 8'h00, 1'b1, 8'hFF, 1'b0, 8'h00);
		// A keyboard reply while the buffer is full is dropped.
		queue_access(ps2kc_pkg::ACT_KBD_REPLY, 16'hFFFF, 8'hFF, 1'b1, 8'h11, 1'b1, 8'h22);
		// Refill from the mouse when only the mouse has a byte, then drain.
		queue_access(ps2kc_pkg::ACT_HOST_READ, port_data, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_READ, port_data, 8'h00, 1'b0, 8'hFF, 1'b0, 8'hFF);
		// A mouse reply into the now empty buffer.
		queue_access(ps2kc_pkg::ACT_MOUSE_REPLY, 16'h0000, 8'h00, 1'b1, 8'h33, 1'b1, 8'h81);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_READ_CTRL,
			1'b0, 8'h00, 1'b0, 8'h00);
		// Control byte write: both interrupts on, both devices off, self-test
		// flag cleared.
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_WRITE_CTRL,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'hFB, 1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_WRITE_MBUF,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_WRITE_KBUF,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00);
		// Output port write with a one-byte command in between: the pending
		// command survives, and an operand with the reset bit clear is flagged.
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_WRITE_OUTP,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_MOUSE_OFF,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_WRITE_OUTP,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'h01, 1'b0, 8'h00, 1'b0, 8'h00);
		// Forwarding to the mouse, then plain data to the keyboard; each
		// loads the device's waiting reply over the buffer at once.
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_TO_MOUSE,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'h5A, 1'b1, 8'h77, 1'b1, 8'h99);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_data, 8'hA5, 1'b1, 8'h44, 1'b1, 8'h55);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_MOUSE_ON,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_KBD_OFF,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, ps2kc_pkg::CMD_KBD_ON,
			1'b0, 8'h00, 1'b0, 8'h00);
		// Refused commands at the range edges, and a code nobody knows.
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, CMD_RAM_RD_LOW,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, CMD_PULSE_LAST,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, CMD_SYS_RESET,
			1'b0, 8'h00, 1'b0, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, port_cmd, CMD_NOT_DEFINED,
			1'b0, 8'h00, 1'b0, 8'h00);
		// Accesses that hit neither port.
		queue_access(ps2kc_pkg::ACT_HOST_READ, 16'hFFFF, 8'h00, 1'b1, 8'h00, 1'b1, 8'h00);
		queue_access(ps2kc_pkg::ACT_HOST_WRITE, 16'h0000, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF);

		run_random_phase(ps2kc_pkg::DAT_PORT_RESET, ps2kc_pkg::CMD_PORT_RESET, 305);
		run_random_phase(16'h0000, 16'hFFFF, 305);
		run_random_phase(16'hFFFF, 16'h0000, 305);
		// Equal addresses: the data port decode takes priority.
		run_random_phase(16'h5AA5, 16'h5AA5, 305);
		run_random_phase(16'($urandom), 16'($urandom), 305);

		wait_until_drained();
		repeat (8) @(negedge clk);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d predicted responses never arrived",
				replies_due.size()));

		$display("Run covered %0d transactions under %0d port settings; %0d kbd and %0d mouse irqs.",
			n_issued, n_settings, n_kirq, n_mirq);
		$display("Error codes: ok %0d, bad address %0d, refused %0d, reset bit %0d, unknown %0d.",
			err_hist[ps2kc_pkg::ERR_OK], err_hist[ps2kc_pkg::ERR_BAD_ADDR],
			err_hist[ps2kc_pkg::ERR_UNIMPL], err_hist[ps2kc_pkg::ERR_RESET_BIT],
			err_hist[ps2kc_pkg::ERR_UNKNOWN]);
		if (n_mismatch == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Watchdog: far longer than the slowest legal run of about 1600 requests
	// with every gap and stall at its longest.
	initial begin
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
